// ----- design/arp_pkg.sv -----
// Shared types and codes for the ARP address cache.
`timescale 1ns / 1ps
package arp_pkg;

  localparam int IP_W       = 32;
  localparam int MAC_W      = 48;
  localparam int IDX_W      = 5;
  localparam int STAT_W     = 2;
  localparam int IN_DATA_W  = 80;  // ip, mac
  localparam int OUT_DATA_W = 56;  // mac, index, pad to bytes

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [MAC_W-1:0] mac;
    logic [IP_W-1:0]  ip;
  } entry_t;

endpackage

// ----- design/arp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module arp_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/arp_address_cache.sv -----
// Top level: IPv4 to MAC binding table with insert and lookup requests.
`timescale 1ns / 1ps
// Usage:
//   Requests come in on the s_ stream: s_tuser is the request kind (0 insert,
//   1 lookup), s_tdata carries the IP in bits 31:0 and the MAC in bits 79:32.
//   Each request gives exactly one result transaction on the m_ stream:
//   m_tuser is the status (0 ok, 1 table full, 2 not found), m_tdata holds
//   the found MAC in bits 47:0 and the entry index in bits 52:48.
//   Every request scans the whole table through the one read port of the
//   entry RAM, one entry per cycle, with a single compare unit on the
//   registered read data. An insert writes its entry in the same cycle as
//   the result is loaded into the result register. One request is in
//   flight at a time; s_tready is high only while the scanner is idle, so a
//   request can be taken while the previous result still waits on m_tready.
//   If the receiver stalls, the finished result of the next request waits in
//   the scanner until the output register frees up.
//   Reset (rst, synchronous) clears all valid bits, so the table is empty;
//   the entry RAM itself is not cleared and needs no clearing pass.
module arp_address_cache #(
  parameter int ENTRIES = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [arp_pkg::IN_DATA_W-1:0]      s_tdata,   // ip_in[31:0], mac_in[79:32]
  input  logic                               s_tuser,   // req_type
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [arp_pkg::OUT_DATA_W-1:0]     m_tdata,   // mac_out[47:0], entry_index[52:48]
  output logic [arp_pkg::STAT_W-1:0]         m_tuser    // status
);

  import arp_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  state_t state, state_next;

  logic [IW-1:0]      scan_idx;
  logic [IW-1:0]      cmp_idx;
  logic               cmp_act;
  logic               req_type;
  logic [IP_W-1:0]    req_ip;
  logic [MAC_W-1:0]   req_mac;
  logic               hit_found;
  logic [IW-1:0]      hit_idx;
  logic [MAC_W-1:0]   hit_mac;
  logic [ENTRIES-1:0] valid;

  logic               out_valid;
  logic [STAT_W-1:0]  out_status;
  logic [MAC_W-1:0]   out_mac;
  logic [IDX_W-1:0]   out_idx;

  entry_t rd_entry;
  entry_t wr_entry;

  logic accept, out_free, finish_go, wr_en;
  logic cur_valid, ip_eq, mac_eq, clear_en, cand;

  assign wr_entry = '{mac: req_mac, ip: req_ip};

  arp_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (hit_idx),
    .wdata (wr_entry),
    .raddr (scan_idx),
    .rdata (rd_entry)
  );

  assign s_tready  = (state == ST_IDLE) && !rst;
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !out_valid || m_tready;
  assign finish_go = (state == ST_FINISH) && out_free;
  assign wr_en     = finish_go && (req_type == REQ_INSERT) && hit_found;

  // compare unit, works on the entry read in the previous cycle
  assign cur_valid = valid[cmp_idx];
  assign ip_eq     = (rd_entry.ip == req_ip);
  assign mac_eq    = (rd_entry.mac == req_mac);
  assign clear_en  = cmp_act && (req_type == REQ_INSERT) && cur_valid && (ip_eq || mac_eq);
  // insert: first entry free after invalidation; lookup: first valid IP hit
  assign cand      = cmp_act && ((req_type == REQ_INSERT) ? (!cur_valid || ip_eq || mac_eq)
                                                          : (cur_valid && ip_eq));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_idx == LAST_IDX) state_next = ST_TAIL;
      end
      ST_TAIL: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      scan_idx  <= '0;
      cmp_act   <= 1'b0;
      hit_found <= 1'b0;
      valid     <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      cmp_act <= (state == ST_SCAN);
      if (accept) begin
        scan_idx  <= '0;
        hit_found <= 1'b0;
      end else begin
        if ((state == ST_SCAN) && (scan_idx != LAST_IDX)) scan_idx <= scan_idx + 1'b1;
        if (cand && !hit_found) hit_found <= 1'b1;
      end
      if (clear_en) valid[cmp_idx] <= 1'b0;
      if (wr_en) valid[hit_idx] <= 1'b1;
      if (finish_go) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmp_idx <= scan_idx;
    if (accept) begin
      req_type <= s_tuser;
      req_ip   <= s_tdata[IP_W-1:0];
      req_mac  <= s_tdata[IP_W +: MAC_W];
    end
    if (cand && !hit_found) begin
      hit_idx <= cmp_idx;
      hit_mac <= rd_entry.mac;
    end
    if (finish_go) begin
      if (hit_found) begin
        out_status <= STAT_OK;
        out_mac    <= (req_type == REQ_LOOKUP) ? hit_mac : '0;
        out_idx    <= IDX_W'(hit_idx);
      end else begin
        out_status <= (req_type == REQ_INSERT) ? STAT_FULL : STAT_NOT_FOUND;
        out_mac    <= '0;
        out_idx    <= '0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {{(OUT_DATA_W - MAC_W - IDX_W){1'b0}}, out_idx, out_mac};

  // the table changes only while a request is being worked on
  a_idle_stable: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |=> $stable(valid))
    else $error("valid bits changed while idle");

  // a lookup never touches occupancy
  a_lookup_stable: assert property (@(posedge clk) disable iff (rst)
    ((state != ST_IDLE) && (req_type == REQ_LOOKUP)) |=> $stable(valid))
    else $error("lookup modified valid bits");

  // table full only when every entry is still valid after invalidation
  a_full_means_full: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_FINISH) && (req_type == REQ_INSERT) && !hit_found) |-> (&valid))
    else $error("table full reported with a free entry");

  // compares only run behind the scan
  a_cmp_in_scan: assert property (@(posedge clk) disable iff (rst)
    cmp_act |-> ((state == ST_SCAN) || (state == ST_TAIL)))
    else $error("compare outside scan");

  // any status other than ok carries zero data
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != STAT_OK)) |-> (m_tdata == '0))
    else $error("nonzero data on error status");

endmodule

// ----- dv/tb_arp_address_cache.sv -----
// Testbench for the ARP address cache: random and directed requests checked against a table model.
`timescale 1ns / 1ps
module tb_arp_address_cache;
  import arp_pkg::*;

  localparam int ENTRIES    = 32;
  localparam int N_RANDOM   = 1600;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic             kind;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } request_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [MAC_W-1:0]  mac;
    logic [IDX_W-1:0]  index;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [STAT_W-1:0] m_tuser;

  // binding table as the testbench sees it
  logic             tbl_valid [ENTRIES];
  logic [IP_W-1:0]  tbl_ip    [ENTRIES];
  logic [MAC_W-1:0] tbl_mac   [ENTRIES];

  request_t pending_reqs[$];
  reply_t   expected_replies[$];

  // recently inserted addresses, so lookups and re-inserts hit the table
  logic [IP_W-1:0]  ip_hist  [64];
  logic [MAC_W-1:0] mac_hist [64];
  int hist_n = 0;

  int errors = 0;
  int cycles = 0;
  int requests_taken = 0;
  int replies_seen = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  logic calm;

  assign calm = (requests_taken >= 700) && (requests_taken < 950);

  arp_address_cache #(.ENTRIES(ENTRIES)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #10 clk = ~clk;

  // apply one request to the table and return the reply it should produce
  function automatic reply_t resolve_request(request_t r);
    reply_t rep;
    rep = '0;
    if (r.kind == REQ_INSERT) begin
      for (int i = 0; i < ENTRIES; i++)
        if (tbl_valid[i] && (tbl_ip[i] == r.ip || tbl_mac[i] == r.mac)) tbl_valid[i] = 1'b0;
      rep.status = STAT_FULL;
      for (int i = 0; i < ENTRIES; i++) begin
        if (!tbl_valid[i]) begin
          tbl_valid[i] = 1'b1;
          tbl_ip[i] = r.ip;
          tbl_mac[i] = r.mac;
          rep.status = STAT_OK;
          rep.index = i[IDX_W-1:0];
          break;
        end
      end
    end else begin
      rep.status = STAT_NOT_FOUND;
      for (int i = 0; i < ENTRIES; i++) begin
        if (tbl_valid[i] && tbl_ip[i] == r.ip) begin
          rep.status = STAT_OK;
          rep.mac = tbl_mac[i];
          rep.index = i[IDX_W-1:0];
          break;
        end
      end
    end
    return rep;
  endfunction

  task automatic queue_request(logic kind, logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac);
    request_t r;
    r.kind = kind;
    r.ip = ip;
    r.mac = mac;
    pending_reqs.push_back(r);
    if (kind == REQ_INSERT) begin
      ip_hist[hist_n % 64] = ip;
      mac_hist[hist_n % 64] = mac;
      hist_n++;
    end
  endtask

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[MAC_W-1:0];
  endfunction

  function automatic logic [IP_W-1:0] hist_ip();
    return ip_hist[$urandom_range((hist_n < 64 ? hist_n : 64) - 1)];
  endfunction

  function automatic logic [MAC_W-1:0] hist_mac();
    return mac_hist[$urandom_range((hist_n < 64 ? hist_n : 64) - 1)];
  endfunction

  // driver
  always @(posedge clk) begin
    request_t nxt;
    request_t taken;
    bit fire;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      fire = s_tvalid && s_tready;
      if (fire) begin
        taken.kind = s_tuser;
        taken.ip = s_tdata[31:0];
        taken.mac = s_tdata[79:32];
        expected_replies.push_back(resolve_request(taken));
        requests_taken <= requests_taken + 1;
      end
      if (s_tvalid && !fire) begin
        // hold the offered transaction
      end else if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 29)) begin
        nxt = pending_reqs.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= nxt.kind;
        s_tdata <= {nxt.mac, nxt.ip};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // monitor and receiver
  always @(posedge clk) begin
    reply_t want;
    logic [MAC_W-1:0] got_mac;
    logic [IDX_W-1:0] got_idx;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_mac = m_tdata[47:0];
        got_idx = m_tdata[52:48];
        replies_seen++;
        if (expected_replies.size() == 0) begin
          errors++;
          $display("%0t: unexpected result status=%0d mac=%h index=%0d",
                   $time, m_tuser, got_mac, got_idx);
        end else begin
          want = expected_replies.pop_front();
          if (m_tuser !== want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, m_tuser);
          end
          if (got_mac !== want.mac) begin
            errors++;
            $display("%0t: mac_out expected %h actual %h", $time, want.mac, got_mac);
          end
          if (got_idx !== want.index) begin
            errors++;
            $display("%0t: entry_index expected %0d actual %0d", $time, want.index, got_idx);
          end
        end
      end
      // one long hold-off so the block backs up and drops s_tready
      if (!hold_done && replies_seen >= 300) begin
        hold_done = 1'b1;
        hold_left = 500;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(99) >= 29);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int n;
    int mode;
    int burst;
    int pick;
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_ip[i] = '0;
      tbl_mac[i] = '0;
    end

    // directed: empty table, extremes, stale-binding cleanup
    queue_request(REQ_LOOKUP, 32'h0, 48'h0);
    queue_request(REQ_INSERT, 32'h0, 48'h0);
    queue_request(REQ_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    queue_request(REQ_LOOKUP, 32'h0, 48'hFFFF_FFFF_FFFF);
    queue_request(REQ_LOOKUP, 32'hFFFF_FFFF, 48'h0);
    queue_request(REQ_INSERT, 32'h0A00_0001, 48'h1);
    queue_request(REQ_INSERT, 32'h0A00_0001, 48'h2);       // same IP, new MAC
    queue_request(REQ_INSERT, 32'h0A00_0002, 48'h2);       // same MAC, new IP
    queue_request(REQ_INSERT, 32'h0, 48'hFFFF_FFFF_FFFF);  // clears two entries
    queue_request(REQ_LOOKUP, 32'hFFFF_FFFF, 48'h0);
    queue_request(REQ_LOOKUP, 32'h0A00_0001, 48'h0);
    queue_request(REQ_LOOKUP, 32'h0A00_0002, 48'h0);
    queue_request(REQ_INSERT, 32'h5555_5555, 48'hAAAA_AAAA_AAAA);
    queue_request(REQ_INSERT, 32'hAAAA_AAAA, 48'h5555_5555_5555);
    queue_request(REQ_LOOKUP, 32'h5555_5555, 48'h1234_5678_9ABC);
    queue_request(REQ_LOOKUP, 32'hAAAA_AAAA, 48'hFFFF_FFFF_FFFF);
    queue_request(REQ_LOOKUP, 32'h0, 48'h0);

    // random bursts: fill with fresh bindings, churn known ones, or pure noise
    n = 0;
    mode = 0;
    while (n < N_RANDOM) begin
      burst = $urandom_range(60, 20);
      for (int k = 0; k < burst; k++) begin
        pick = $urandom_range(99);
        if (mode < 4) begin
          if (pick < 75) queue_request(REQ_INSERT, $urandom, rand_mac());
          else queue_request(REQ_LOOKUP, hist_ip(), rand_mac());
        end else if (mode < 8) begin
          if (pick < 60) queue_request(REQ_INSERT, hist_ip(), hist_mac());
          else if (pick < 90) queue_request(REQ_LOOKUP, hist_ip(), rand_mac());
          else queue_request(REQ_LOOKUP, $urandom, rand_mac());
        end else begin
          if (pick < 10) queue_request(REQ_INSERT, 32'hFFFF_FFFF, 48'h0);
          else if (pick < 20) queue_request(REQ_INSERT, 32'h0, 48'hFFFF_FFFF_FFFF);
          else queue_request(1'($urandom_range(1)), $urandom, rand_mac());
        end
        n++;
      end
      mode = $urandom_range(9);
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (pending_reqs.size() != 0 || s_tvalid || expected_replies.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);

    if (errors == 0 && expected_replies.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
